// File: rtl/bced_pkg.sv
// shared types and constants for the button click event detector
package bced_pkg;

  localparam int NUM_KEYS = 4;
  localparam int PIN_W    = 4;
  localparam int KEY_W    = 2;
  localparam int CNT_W    = 8;
  localparam int REG_W    = 2;

  localparam logic [CNT_W-1:0] FILTER_MAX = 8'd255;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [REG_W-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [REG_W-1:0] REG_DOUBLE_WAIT = 2'd2;
  localparam logic [REG_W-1:0] REG_LONG_REPEAT = 2'd3;

  // request opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // sticky event bits
  localparam logic [2:0] EV_SINGLE = 3'b001;
  localparam logic [2:0] EV_DOUBLE = 3'b010;
  localparam logic [2:0] EV_LONG   = 3'b100;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_PRESS1_DB,
    PH_HELD1,
    PH_REL1_DB,
    PH_DBL_WAIT,
    PH_PRESS2_DB,
    PH_HELD2,
    PH_REL2_DB,
    PH_FINAL,
    PH_LONG
  } phase_t;

  typedef enum logic [1:0] {
    CLICK_NONE,
    CLICK_SINGLE,
    CLICK_DOUBLE,
    CLICK_LONG
  } click_t;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_len;
    logic [CNT_W-1:0] long_press_len;
    logic [CNT_W-1:0] double_wait_len;
    logic [CNT_W-1:0] long_repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic             opcode;
    logic [PIN_W-1:0] pin_levels;
    logic [KEY_W-1:0] key_select;
  } in_req_t;

  typedef struct packed {
    logic [7:0] click_state_vec;
    logic [3:0] held_mask;
    logic [3:0] single_pulse_mask;
    logic [3:0] double_pulse_mask;
    logic [3:0] long_repeat_mask;
    logic [2:0] taken_events;
  } out_rsp_t;

  // what one lane reports to the merge stage
  typedef struct packed {
    click_t     click;
    logic       held;
    logic       single;
    logic       dbl;
    logic       rep;
    logic [2:0] sticky;
  } lane_stat_t;

endpackage

// File: rtl/button_click_event_detector.sv
// top level of the button click event detector
// Classifies four active-low buttons, one lane per key, as single, double or long
// presses. Each request is either a scan tick carrying raw pin levels (0 = pressed)
// or a take that returns and clears the sticky event bits of one key. Every request
// gives exactly one result: the per-key click state, the debounced held mask, the
// single, double and long-repeat pulse masks of this tick, and the take result.
// All lanes update in parallel in the same cycle and a merge stage packs their
// reports into the result register, so one request is accepted per clock; the only
// limit on rate is downstream stall, which holds the input off only while a result
// sits unaccepted in the register.
// Configuration registers (debounce, long press, double wait, long repeat) are
// written through the cfg port, which is always ready; write them while idle.
module button_click_event_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bced_pkg::in_req_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bced_pkg::out_rsp_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bced_pkg::REG_W-1:0]    cfg_index,
  input  logic [bced_pkg::CNT_W-1:0]    cfg_data
);
  import bced_pkg::*;

  cfg_t                       cfg_r, cfg_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_rsp_t                   out_data_r;
  out_rsp_t                   rsp;
  lane_stat_t [NUM_KEYS-1:0]  lanes;
  logic                       in_acc;
  logic                       tick;
  logic                       take;

  // configuration write port, never stalls
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:    cfg_nxt.debounce_len      = cfg_data;
        REG_LONG_PRESS:  cfg_nxt.long_press_len    = cfg_data;
        REG_DOUBLE_WAIT: cfg_nxt.double_wait_len   = cfg_data;
        REG_LONG_REPEAT: cfg_nxt.long_repeat_ticks = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // input is held off only while the result register is full and stalled
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign tick     = in_acc & (in_data.opcode == OP_TICK);
  assign take     = in_acc & (in_data.opcode == OP_TAKE);

  // one lane per key; keys above the pin field read as released
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic pressed;
    if (k < PIN_W) begin : g_pin
      assign pressed = ~in_data.pin_levels[k];
    end else begin : g_nopin
      assign pressed = 1'b0;
    end
    bced_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .tick    (tick),
      .clear   (take & (in_data.key_select == KEY_W'(k))),
      .pressed (pressed),
      .cfg     (cfg_r),
      .stat    (lanes[k])
    );
  end

  bced_merge u_merge (
    .opcode     (in_data.opcode),
    .key_select (in_data.key_select),
    .lanes      (lanes),
    .rsp        (rsp)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r              <= 1'b0;
      cfg_r.debounce_len       <= 8'd1;
      cfg_r.long_press_len     <= 8'd50;
      cfg_r.double_wait_len    <= 8'd40;
      cfg_r.long_repeat_ticks  <= 8'd4;
    end else begin
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // the input only stalls behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  // a take result carries no pulses
  a_take_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.taken_events != 3'd0) |->
      (out_data.single_pulse_mask == 4'd0 && out_data.double_pulse_mask == 4'd0 &&
       out_data.long_repeat_mask == 4'd0))
    else $error("take result with pulse bits set");

  // a single click pulse shows the single state on key 0
  a_single_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.single_pulse_mask[0]) |->
      (out_data.click_state_vec[1:0] == CLICK_SINGLE))
    else $error("single pulse without single state");

  // a double click pulse shows the double state on key 0
  a_double_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.double_pulse_mask[0]) |->
      (out_data.click_state_vec[1:0] == CLICK_DOUBLE))
    else $error("double pulse without double state");
`endif

endmodule

// File: rtl/bced_lane.sv
// one key lane: debounce filter, click phase machine and sticky events
module bced_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick,
  input  logic                clear,
  input  logic                pressed,
  input  bced_pkg::cfg_t      cfg,
  output bced_pkg::lane_stat_t stat
);
  import bced_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] phase_count_r, phase_count_nxt;
  logic [CNT_W-1:0] repeat_count_r, repeat_count_nxt;
  click_t           logic_state_r, logic_state_nxt;
  logic [2:0]       sticky_r, sticky_nxt;
  logic             cand_r, cand_nxt;
  logic [CNT_W-1:0] filter_count_r, filter_count_nxt;
  logic             held_r, held_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] rep_inc;
  logic [CNT_W-1:0] filt_sat;
  logic [2:0]       ev_set;
  logic [2:0]       pulses;

  assign cnt_inc  = phase_count_r + 8'd1;
  assign rep_inc  = repeat_count_r + 8'd1;
  assign filt_sat = (filter_count_r == FILTER_MAX) ? filter_count_r : filter_count_r + 8'd1;

  // debounce filter
  always_comb begin
    cand_nxt         = cand_r;
    filter_count_nxt = filter_count_r;
    held_nxt         = held_r;
    if (pressed != cand_r) begin
      cand_nxt         = pressed;
      filter_count_nxt = '0;
    end else if (held_r != pressed) begin
      filter_count_nxt = filt_sat;
      if (filt_sat >= cfg.debounce_len) begin
        held_nxt = pressed;
      end
    end
  end

  // next phase and counters
  always_comb begin
    phase_nxt        = phase_r;
    phase_count_nxt  = phase_count_r;
    repeat_count_nxt = repeat_count_r;
    case (phase_r)
      PH_IDLE: begin
        if (pressed) begin
          phase_nxt       = PH_PRESS1_DB;
          phase_count_nxt = '0;
        end
      end
      PH_PRESS1_DB, PH_PRESS2_DB: begin
        if (pressed) begin
          if (cnt_inc >= cfg.debounce_len) begin
            phase_nxt       = (phase_r == PH_PRESS1_DB) ? PH_HELD1 : PH_HELD2;
            phase_count_nxt = '0;
          end else begin
            phase_count_nxt = cnt_inc;
          end
        end else if (phase_r == PH_PRESS1_DB) begin
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt       = PH_DBL_WAIT;
          phase_count_nxt = '0;
        end
      end
      PH_HELD1: begin
        phase_count_nxt = cnt_inc;
        if (!pressed) begin
          if (cnt_inc < cfg.long_press_len) begin
            phase_nxt       = PH_REL1_DB;
            phase_count_nxt = '0;
          end else begin
            phase_nxt = PH_FINAL;
          end
        end else if (cnt_inc >= cfg.long_press_len) begin
          phase_nxt = PH_LONG;
        end
      end
      PH_REL1_DB: begin
        if (!pressed) begin
          if (cnt_inc >= cfg.debounce_len) begin
            phase_nxt       = PH_DBL_WAIT;
            phase_count_nxt = '0;
          end else begin
            phase_count_nxt = cnt_inc;
          end
        end else begin
          phase_nxt       = PH_HELD1;
          phase_count_nxt = '0;
        end
      end
      PH_DBL_WAIT: begin
        phase_count_nxt = cnt_inc;
        if (pressed) begin
          if (cnt_inc < cfg.double_wait_len) begin
            phase_nxt       = PH_PRESS2_DB;
            phase_count_nxt = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else if (cnt_inc >= cfg.double_wait_len) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HELD2: begin
        phase_count_nxt = cnt_inc;
        if (!pressed) begin
          phase_nxt       = PH_REL2_DB;
          phase_count_nxt = '0;
        end else if (cnt_inc >= cfg.long_press_len) begin
          phase_nxt       = PH_LONG;
          phase_count_nxt = '0;
        end
      end
      PH_REL2_DB: begin
        if (!pressed) begin
          phase_count_nxt = cnt_inc;
          if (cnt_inc >= cfg.debounce_len) begin
            phase_nxt = PH_FINAL;
          end
        end else begin
          phase_nxt       = PH_HELD2;
          phase_count_nxt = '0;
        end
      end
      PH_FINAL: begin
        phase_nxt       = PH_IDLE;
        phase_count_nxt = '0;
      end
      PH_LONG: begin
        if (!pressed) begin
          phase_nxt        = PH_IDLE;
          phase_count_nxt  = '0;
          repeat_count_nxt = '0;
        end else if (rep_inc >= cfg.long_repeat_ticks) begin
          repeat_count_nxt = '0;
        end else begin
          repeat_count_nxt = rep_inc;
        end
      end
      default: begin
        phase_nxt       = PH_IDLE;
        phase_count_nxt = '0;
      end
    endcase
  end

  // logical state, event bits and pulses
  always_comb begin
    logic_state_nxt = logic_state_r;
    ev_set          = '0;
    pulses          = '0;
    case (phase_r)
      PH_IDLE, PH_PRESS1_DB, PH_PRESS2_DB, PH_FINAL: begin
        logic_state_nxt = CLICK_NONE;
      end
      PH_HELD1: begin
        if (!pressed) begin
          logic_state_nxt = (cnt_inc < cfg.long_press_len) ? CLICK_SINGLE : CLICK_NONE;
        end else if (cnt_inc >= cfg.long_press_len) begin
          logic_state_nxt = CLICK_LONG;
          ev_set          = EV_LONG;
        end else begin
          logic_state_nxt = CLICK_NONE;
        end
      end
      PH_REL1_DB: begin
        if (!pressed && cnt_inc >= cfg.debounce_len) begin
          logic_state_nxt = CLICK_SINGLE;
          ev_set          = EV_SINGLE;
          pulses[0]       = 1'b1;
        end
      end
      PH_DBL_WAIT: begin
        // a timely second press keeps the current state for now
        if (!(pressed && cnt_inc < cfg.double_wait_len)) begin
          logic_state_nxt = CLICK_NONE;
        end
      end
      PH_HELD2: begin
        if (pressed && cnt_inc >= cfg.long_press_len) begin
          logic_state_nxt = CLICK_LONG;
          ev_set          = EV_LONG;
        end else begin
          logic_state_nxt = CLICK_NONE;
        end
      end
      PH_REL2_DB: begin
        if (!pressed && cnt_inc >= cfg.debounce_len) begin
          logic_state_nxt = CLICK_DOUBLE;
          ev_set          = EV_DOUBLE;
          pulses[1]       = 1'b1;
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          logic_state_nxt = CLICK_NONE;
        end else begin
          logic_state_nxt = CLICK_LONG;
          pulses[2]       = (rep_inc >= cfg.long_repeat_ticks);
        end
      end
      default: begin
        logic_state_nxt = CLICK_NONE;
      end
    endcase
  end

  always_comb begin
    sticky_nxt = sticky_r;
    if (tick) begin
      sticky_nxt = sticky_r | ev_set;
    end else if (clear) begin
      sticky_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      phase_count_r  <= '0;
      repeat_count_r <= '0;
      logic_state_r  <= CLICK_NONE;
      sticky_r       <= '0;
      cand_r         <= 1'b0;
      filter_count_r <= '0;
      held_r         <= 1'b0;
    end else begin
      sticky_r <= sticky_nxt;
      if (tick) begin
        phase_r        <= phase_nxt;
        phase_count_r  <= phase_count_nxt;
        repeat_count_r <= repeat_count_nxt;
        logic_state_r  <= logic_state_nxt;
        cand_r         <= cand_nxt;
        filter_count_r <= filter_count_nxt;
        held_r         <= held_nxt;
      end
    end
  end

  // report click state and held flag as they stand after this request, sticky bits as before it
  assign stat.click  = tick ? logic_state_nxt : logic_state_r;
  assign stat.held   = tick ? held_nxt : held_r;
  assign stat.single = tick & pulses[0];
  assign stat.dbl    = tick & pulses[1];
  assign stat.rep    = tick & pulses[2];
  assign stat.sticky = sticky_r;

endmodule

// File: rtl/bced_merge.sv
// merge stage: packs the lane reports into one result
module bced_merge (
  input  logic                                          opcode,
  input  logic [bced_pkg::KEY_W-1:0]                    key_select,
  input  bced_pkg::lane_stat_t [bced_pkg::NUM_KEYS-1:0] lanes,
  output bced_pkg::out_rsp_t                            rsp
);
  import bced_pkg::*;

  always_comb begin
    rsp = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (k < PIN_W) begin
        rsp.click_state_vec[2*k +: 2] = lanes[k].click;
        rsp.held_mask[k]              = lanes[k].held;
        rsp.single_pulse_mask[k]      = lanes[k].single;
        rsp.double_pulse_mask[k]      = lanes[k].dbl;
        rsp.long_repeat_mask[k]       = lanes[k].rep;
      end
      // a key select with no lane behind it matches nothing and reads zero
      if (opcode == OP_TAKE && key_select == KEY_W'(k)) begin
        rsp.taken_events = lanes[k].sticky;
      end
    end
  end

endmodule
